### rtl/jddm_pkg.sv
package jddm_pkg;

  localparam int STICK_FULL_SCALE = 2000;
  localparam int QW = 17;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PWM_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL     = 3'd5;

  localparam logic signed [QW-1:0] Q_ONE = 17'sd32768;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM_F,
    ST_SQRT_F,
    ST_NORM_T,
    ST_SQRT_T,
    ST_MIX,
    ST_SLEW_L,
    ST_SLEW_R,
    ST_PWM,
    ST_OUT
  } state_t;

  function automatic logic [16:0] mag17(input logic signed [17:0] v);
    logic [17:0] a;
    a = v[17] ? 18'(-v) : 18'(v);
    return a[16:0];
  endfunction

  function automatic logic signed [QW-1:0] clampq(input logic signed [18:0] v);
    if (v > 19'sd32768) return Q_ONE;
    if (v < -19'sd32768) return -Q_ONE;
    return v[QW-1:0];
  endfunction

endpackage

### rtl/joystick_differential_drive_mixer.sv
// Arcade-drive mixer with slew-limited wheel speeds. A stick beat is taken only from idle, and
// no new beat is taken until its result has left the output. Each stick gets a normalize
// (reciprocal multiply plus one correction step on the shared multiplier) and a square root
// in the shared root unit. Mixing, the two slew steps and the two PWM products then run on the
// shared multiplier. in_stall is high the whole time a beat is in work or its result waits on
// out_stall, and a stalled output holds the result and delays the next beat.
module joystick_differential_drive_mixer #(
  parameter int FULL_SCALE = jddm_pkg::STICK_FULL_SCALE
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [11:0]              in_forward_stick,
  input  logic signed [11:0]              in_turn_stick,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [16:0]              out_left_cmd,
  output logic signed [16:0]              out_right_cmd,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [jddm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_data
);
  import jddm_pkg::*;

  localparam logic [15:0] FS = 16'(FULL_SCALE);
  localparam logic [19:0] RECIP = 20'((1 << 27) / FULL_SCALE);

  logic [15:0] pwm_limit_r, lin_r, ang_r, acc_r, dec_r;
  logic [10:0] dz_r;
  state_t state_r, state_nxt;
  logic signed [11:0] fs_r, ts_r;
  logic signed [QW-1:0] f_r, t_r, lsp_r, rsp_r, tl_r, tr_r;
  logic signed [16:0] lp_r, rp_r;
  logic [3:0] sub_r;
  logic [16:0] quo_r;
  logic sq_start;
  logic sq_done;
  logic [15:0] sq_root;
  logic [31:0] sq_rad;
  logic [19:0] m_a;
  logic [15:0] m_b;
  logic [35:0] m_p;
  logic [35:0] prod_r;
  logic signed [16:0] base_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_limit_r <= 16'd40000; dz_r <= 11'd300; lin_r <= 16'd52429;
      ang_r <= 16'd39322; acc_r <= 16'd3277; dec_r <= 16'd13107;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PWM_LIMIT: pwm_limit_r <= cfg_data;
        REG_DEAD_ZONE: dz_r <= cfg_data[10:0];
        REG_LIN_GAIN:  lin_r <= cfg_data;
        REG_ANG_GAIN:  ang_r <= cfg_data;
        REG_ACCEL:     acc_r <= cfg_data;
        REG_DECEL:     dec_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared root unit and shared multiplier
  assign sq_rad = {quo_r, 15'd0};
  jddm_sqrt u_sqrt (.clk, .rst_n, .start(sq_start), .radicand(sq_rad),
                    .done(sq_done), .root(sq_root));
  assign m_p = 36'(m_a) * 36'(m_b);

  logic signed [11:0] cur_s;
  logic [11:0] cur_m;
  logic signed [QW-1:0] cur_sp, cur_tg;
  logic signed [17:0] diff;
  logic [16:0] dmag, smag, tmag;
  logic signed [17:0] nsp;
  logic signed [QW-1:0] shaped;
  logic [16:0] mag_p;
  logic signed [17:0] sgnp;
  logic [23:0] q_est;
  logic [26:0] rem_v;

  always_comb begin
    cur_s = (state_r == ST_NORM_F || state_r == ST_SQRT_F) ? fs_r : ts_r;
    cur_m = cur_s[11] ? 12'(-cur_s) : 12'(cur_s);
    cur_sp = (state_r == ST_SLEW_L) ? lsp_r : rsp_r;
    cur_tg = (state_r == ST_SLEW_L) ? tl_r : tr_r;
    diff = 18'(cur_tg) - 18'(cur_sp);
    dmag = mag17(diff);
    smag = mag17(18'(cur_sp));
    tmag = mag17(18'(cur_tg));
    m_a = '0; m_b = '0;
    case (state_r)
      ST_NORM_F, ST_NORM_T: begin
        m_a = (sub_r == 4'd0) ? RECIP : {3'b000, quo_r};
        m_b = (sub_r == 4'd0) ? {4'b0000, cur_m} : FS;
      end
      ST_MIX:    begin m_a = 20'(sub_r[0] ? mag17(18'(t_r)) : mag17(18'(f_r)));
                       m_b = sub_r[0] ? ang_r : lin_r; end
      ST_SLEW_L, ST_SLEW_R: begin m_a = 20'(dmag); m_b = (dmag > smag) ? acc_r : dec_r; end
      ST_PWM:    begin m_a = 20'(sub_r[0] ? mag17(18'(rsp_r)) : mag17(18'(lsp_r)));
                       m_b = pwm_limit_r; end
      default: ;
    endcase
    mag_p = prod_r[32:16];
    q_est = prod_r[35:12];
    rem_v = {cur_m, 15'd0} - prod_r[26:0];
    shaped = (cur_s[11]) ? -QW'({1'b0, sq_root}) : QW'({1'b0, sq_root});
    nsp = 18'(cur_sp) + (diff[17] ? -18'(mag_p) : 18'(mag_p));
    sgnp = 18'(mag_p);
  end

  // sequencer: sub_r 0 = issue multiply, 1 = use product
  always_comb begin
    state_nxt = state_r;
    sq_start = 1'b0;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_NORM_F;
      ST_NORM_F, ST_NORM_T: if (sub_r == 4'd4) begin
        sq_start = 1'b1;
        state_nxt = (state_r == ST_NORM_F) ? ST_SQRT_F : ST_SQRT_T;
      end
      ST_SQRT_F: if (sq_done) state_nxt = ST_NORM_T;
      ST_SQRT_T: if (sq_done) state_nxt = ST_MIX;
      ST_MIX:    if (sub_r == 4'd2) state_nxt = ST_SLEW_L;
      ST_SLEW_L: if (sub_r == 4'd1) state_nxt = ST_SLEW_R;
      ST_SLEW_R: if (sub_r == 4'd1) state_nxt = ST_PWM;
      ST_PWM:    if (sub_r == 4'd3) state_nxt = ST_OUT;
      ST_OUT:    if (!out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sub_r <= '0;
      lsp_r <= '0;
      rsp_r <= '0;
    end else begin
      state_r <= state_nxt;
      sub_r <= (state_nxt != state_r) ? 4'd0 : sub_r + 4'd1;
      prod_r <= m_p;
      case (state_r)
        ST_IDLE: if (in_valid) begin fs_r <= in_forward_stick; ts_r <= in_turn_stick; end
        ST_NORM_F, ST_NORM_T: begin
          // reciprocal estimate is exact or one low; saturate, then correct once
          if (sub_r == 4'd1) quo_r <= (q_est >= 24'd32768) ? 17'd32768 : q_est[16:0];
          if (sub_r == 4'd3 && quo_r != 17'd32768 && rem_v >= 27'(FS))
            quo_r <= quo_r + 17'd1;
        end
        ST_SQRT_F, ST_SQRT_T: if (sq_done) begin
          if (state_r == ST_SQRT_F) f_r <= (cur_m < 12'(dz_r)) ? '0 : shaped;
          else t_r <= (cur_m < 12'(dz_r)) ? '0 : shaped;
        end
        ST_MIX: begin
          if (sub_r == 4'd1) base_r <= f_r[QW-1] ? -17'(sgnp) : 17'(sgnp);
          if (sub_r == 4'd2) begin
            tl_r <= clampq(19'(base_r) - (t_r[QW-1] ? -19'(sgnp) : 19'(sgnp)));
            tr_r <= clampq(19'(base_r) + (t_r[QW-1] ? -19'(sgnp) : 19'(sgnp)));
          end
        end
        ST_SLEW_L, ST_SLEW_R: if (sub_r == 4'd1) begin
          if (mag17(nsp) * 7'd100 < 24'd32768 && 22'(tmag) * 5'd20 < 22'd32768) begin
            if (state_r == ST_SLEW_L) lsp_r <= '0; else rsp_r <= '0;
          end else if (state_r == ST_SLEW_L) lsp_r <= nsp[QW-1:0];
          else rsp_r <= nsp[QW-1:0];
        end
        ST_PWM: begin
          if (sub_r == 4'd1)
            lp_r <= lsp_r[QW-1] ? -17'(prod_r[31:15]) : 17'(prod_r[31:15]);
          if (sub_r == 4'd2)
            rp_r <= rsp_r[QW-1] ? -17'(prod_r[31:15]) : 17'(prod_r[31:15]);
        end
        default: ;
      endcase
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_left_cmd = lp_r;
  assign out_right_cmd = rp_r;

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_left_cmd))
    else $error("result dropped under stall");
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    lsp_r <= Q_ONE && lsp_r >= -Q_ONE) else $error("left speed out of range");
`endif
endmodule

### rtl/jddm_sqrt.sv
module jddm_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] radicand,
  output logic        done,
  output logic [15:0] root
);
  logic [31:0] x_r, x_nxt;
  logic [31:0] res_r, res_nxt;
  logic [31:0] bit_r, bit_nxt;
  logic        busy_r, busy_nxt;
  logic [31:0] trial;

  always_comb begin
    x_nxt = x_r;
    res_nxt = res_r;
    bit_nxt = bit_r;
    busy_nxt = busy_r;
    trial = res_r + bit_r;
    if (start) begin
      x_nxt = radicand;
      res_nxt = '0;
      bit_nxt = 32'h4000_0000;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_nxt = x_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r == 32'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    x_r <= x_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign done = !busy_r;
  assign root = res_r[15:0];
endmodule

### tb/tb_joystick_differential_drive_mixer.sv
module tb_joystick_differential_drive_mixer;
  timeunit 1ns;
  timeprecision 1ps;
  import jddm_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [11:0] in_forward_stick = '0;
  logic signed [11:0] in_turn_stick = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [16:0] out_left_cmd;
  logic signed [16:0] out_right_cmd;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  joystick_differential_drive_mixer dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  typedef struct packed {
    logic signed [16:0] left;
    logic signed [16:0] right;
  } pwm_pair_t;

  pwm_pair_t pwm_queue[$];
  int unsigned errors = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  logic [15:0] m_pwm, m_lin, m_ang, m_acc, m_dec;
  logic [10:0] m_dz;
  longint m_lspd, m_rspd;

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint gain_mul(longint v, longint g);
    longint p;
    p = (absv(v) * g) >>> 16;
    return v < 0 ? -p : p;
  endfunction

  function automatic longint sat_q(longint v);
    if (v > 32768) return 32768;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint shape_stick(logic signed [11:0] s);
    longint m, n, r, b;
    m = absv(longint'(s));
    if (m < longint'(m_dz)) return 0;
    n = (m * 32768) / STICK_FULL_SCALE;
    if (n > 32768) n = 32768;
    n = n * 32768;
    r = 0;
    b = longint'(1) << 30;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return s < 0 ? -r : r;
  endfunction

  function automatic longint slew_speed(longint spd, longint tgt);
    longint diff;
    diff = tgt - spd;
    spd += gain_mul(diff, absv(diff) > absv(spd) ? longint'(m_acc) : longint'(m_dec));
    if (absv(spd) * 100 < 32768 && absv(tgt) * 20 < 32768) spd = 0;
    return spd;
  endfunction

  function automatic logic signed [16:0] speed_to_pwm(longint spd);
    longint p;
    p = (absv(spd) * longint'(m_pwm)) >>> 15;
    return 17'(spd < 0 ? -p : p);
  endfunction

  function automatic pwm_pair_t predict_pwm(logic signed [11:0] f, logic signed [11:0] t);
    longint base, adj;
    pwm_pair_t r;
    base = gain_mul(shape_stick(f), m_lin);
    adj = gain_mul(shape_stick(t), m_ang);
    m_lspd = slew_speed(m_lspd, sat_q(base - adj));
    m_rspd = slew_speed(m_rspd, sat_q(base + adj));
    r.left = speed_to_pwm(m_lspd);
    r.right = speed_to_pwm(m_rspd);
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PWM_LIMIT: m_pwm = val;
      REG_DEAD_ZONE: m_dz = val[10:0];
      REG_LIN_GAIN:  m_lin = val;
      REG_ANG_GAIN:  m_ang = val;
      REG_ACCEL:     m_acc = val;
      REG_DECEL:     m_dec = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pwm_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_beat(logic signed [11:0] f, logic signed [11:0] t, bit has_want,
                           pwm_pair_t want);
    pwm_pair_t p;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_forward_stick <= f;
    in_turn_stick <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_pwm(f, t);
    if (has_want && p != want) begin
      $display("%0t predictor disagrees with table: exp %0d %0d got %0d %0d", $time,
               want.left, want.right, p.left, p.right);
      errors++;
    end
    pwm_queue.push_back(has_want ? want : p);
    beats_in++;
  endtask

  always @(posedge clk) begin
    pwm_pair_t e;
    if (rst_n && out_valid && !out_stall) begin
      beats_out++;
      if (pwm_queue.size() == 0) begin
        $display("%0t unexpected beat: left %0d right %0d", $time, out_left_cmd,
                 out_right_cmd);
        errors++;
      end else begin
        e = pwm_queue.pop_front();
        if (e.left !== out_left_cmd) begin
          $display("%0t left cmd exp %0d act %0d", $time, e.left, out_left_cmd);
          errors++;
        end
        if (e.right !== out_right_cmd) begin
          $display("%0t right cmd exp %0d act %0d", $time, e.right, out_right_cmd);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  typedef struct {
    logic signed [11:0] f;
    logic signed [11:0] t;
    bit has_want;
    pwm_pair_t want;
  } stim_row_t;

  stim_row_t rows[] = '{
    '{12'sd0, 12'sd0, 1'b1, '{17'sd0, 17'sd0}},
    '{12'sd299, -12'sd299, 1'b1, '{17'sd0, 17'sd0}},
    '{12'sd2047, 12'sd0, 1'b0, '0},
    '{12'sd2047, 12'sd0, 1'b0, '0},
    '{12'sh800, 12'sd0, 1'b0, '0},
    '{12'sd0, 12'sd2047, 1'b0, '0},
    '{12'sd0, 12'sh800, 1'b0, '0},
    '{12'sd2000, 12'sd2000, 1'b0, '0},
    '{-12'sd2000, -12'sd2000, 1'b0, '0},
    '{12'sd300, 12'sd300, 1'b0, '0},
    '{12'sd1000, -12'sd1500, 1'b0, '0},
    '{12'sd0, 12'sd0, 1'b0, '0},
    '{12'sd0, 12'sd0, 1'b0, '0}
  };

  initial begin
    logic signed [11:0] f, t;
    int phase;
    m_pwm = 40000; m_dz = 300; m_lin = 52429; m_ang = 39322;
    m_acc = 3277; m_dec = 13107;
    m_lspd = 0; m_rspd = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send_beat(rows[i].f, rows[i].t, rows[i].has_want, rows[i].want);
    drain();
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 47; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 47; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      drain();
      case (phase)
        0: ;
        1: begin
          write_reg(REG_PWM_LIMIT, 16'hFFFF); write_reg(REG_DEAD_ZONE, 16'd0);
          write_reg(REG_LIN_GAIN, 16'hFFFF); write_reg(REG_ANG_GAIN, 16'hFFFF);
          write_reg(REG_ACCEL, 16'hFFFF); write_reg(REG_DECEL, 16'hFFFF);
        end
        2: begin
          write_reg(REG_PWM_LIMIT, 16'd0); write_reg(REG_DEAD_ZONE, 16'd2047);
          write_reg(REG_ACCEL, 16'd0); write_reg(REG_DECEL, 16'd0);
        end
        7: begin
          write_reg(3'd6, 16'h1234); write_reg(3'd7, 16'hFFFF);
          write_reg(REG_DEAD_ZONE, 16'd300);
        end
        default: begin
          write_reg(REG_PWM_LIMIT, 16'($urandom));
          write_reg(REG_DEAD_ZONE, 16'($urandom_range(600)));
          write_reg(REG_LIN_GAIN, 16'($urandom)); write_reg(REG_ANG_GAIN, 16'($urandom));
          write_reg(REG_ACCEL, 16'($urandom)); write_reg(REG_DECEL, 16'($urandom));
        end
      endcase
      cfg_valid <= 1'b0;
      repeat (235) begin
        case ($urandom_range(3))
          0: begin f = 12'($urandom); t = 12'($urandom); end
          1: begin f = 12'($urandom_range(4095)); t = 12'sd0; end
          2: begin f = 12'sd0; t = 12'sd0; end
          default: begin f = $urandom_range(1) ? 12'sd2047 : 12'sh800; t = 12'($urandom); end
        endcase
        send_beat(f, t, 1'b0, '0);
      end
    end
    idle_pct = 0; stall_pct = 0;
    drain();
    $display("sent %0d stick beats, checked %0d wheel command beats over 8 register settings",
             beats_in, beats_out);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

### files.f
rtl/jddm_pkg.sv
rtl/jddm_sqrt.sv
rtl/joystick_differential_drive_mixer.sv
tb/tb_joystick_differential_drive_mixer.sv
